// File: rtl/stable_priority_queue_assert.svh
// Assertion macros used by the priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spq_pkg.sv
// Shared types and constants of the stable priority queue.
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_BITS  = 8;
    localparam int DATA_BITS = 32;
    localparam int TAG_BITS  = 32;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int MODE_BITS = 2;
    localparam int STAT_BITS = 2;

    localparam int IN_BITS  = MODE_BITS + KEY_BITS + DATA_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STAT_BITS + KEY_BITS + DATA_BITS + TAG_BITS + CNT_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD  = OUT_W - OUT_BITS;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PRIO = 2'd0,
        MODE_FIFO = 2'd1,
        MODE_POP  = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INS_PRIO,
        CMD_INS_TAIL,
        CMD_POP
    } cmd_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  sev;
        logic [DATA_BITS-1:0] pay;
        logic [TAG_BITS-1:0]  tag;
    } data_t;

    typedef struct packed {
        logic  valid;
        data_t data;
    } entry_t;

    // Broadcast to every cell in a cycle.
    typedef struct packed {
        cmd_t  cmd;
        data_t new_data;
    } ctl_t;

endpackage

// File: rtl/spq_cell.sv
// One slot of the shift-register queue, with its insert-position link.
module spq_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  spq_pkg::ctl_t  ctl,
    input  spq_pkg::entry_t left_in,
    input  spq_pkg::entry_t right_in,
    input  logic           found_in,
    output logic           found_out,
    output spq_pkg::entry_t entry_out
);
    import spq_pkg::*;

    logic   valid_reg, valid_next;
    data_t  data_reg, data_next;
    logic   claim;

    // A slot claims the new entry if it is empty, or, for a priority insert,
    // if its key is strictly greater than the new one.
    always_comb begin
        if (ctl.cmd == CMD_INS_TAIL) begin
            claim = !valid_reg;
        end else begin
            claim = !valid_reg || (data_reg.sev > ctl.new_data.sev);
        end
        found_out = found_in || claim;
    end

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (ctl.cmd)
            CMD_INS_PRIO, CMD_INS_TAIL: begin
                if (found_in) begin
                    valid_next = left_in.valid;
                    data_next  = left_in.data;
                end else if (claim) begin
                    valid_next = 1'b1;
                    data_next  = ctl.new_data;
                end
            end
            CMD_POP: begin
                valid_next = right_in.valid;
                data_next  = right_in.data;
            end
            default: begin
                valid_next = valid_reg;
                data_next  = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign entry_out = '{valid: valid_reg, data: data_reg};

endmodule

// File: rtl/stable_priority_queue.sv
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one operation per cycle unless m_tready stalls; every cell compares and shifts at once.
// The insert position travels through the cell row as a ripple-found chain.
// s_tready is low only while a finished result waits on a stalled m_tready.
// Reset (aresetn low at a clock edge) empties the queue and sets the tag to 1.
// Stored entries need no clearing: only cells with a set valid bit are read.
module stable_priority_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata: mode[1:0], severity[9:2], payload[41:10], zero fill above.
    input  logic [spq_pkg::IN_W-1:0]    s_tdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // m_tdata: status[1:0], out_severity[9:2], out_payload[41:10],
    // out_tag[73:42], occupancy[78:74], zero fill above.
    output logic [spq_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready
);
    import spq_pkg::*;

    `include "stable_priority_queue_assert.svh"

    // Input beat fields.
    mode_t                 in_mode;
    logic [KEY_BITS-1:0]   in_sev;
    logic [DATA_BITS-1:0]  in_pay;

    assign in_mode = mode_t'(s_tdata[MODE_BITS-1:0]);
    assign in_sev  = s_tdata[MODE_BITS +: KEY_BITS];
    assign in_pay  = s_tdata[MODE_BITS + KEY_BITS +: DATA_BITS];

    // Queue bookkeeping.
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic                 s_fire;
    logic                 full, empty, push_ok;
    ctl_t                 ctl;

    // The cell row. Link slot 0 and slot DEPTH+1 are permanently empty ends;
    // cell i shows its contents on slot i+1.
    entry_t               link   [DEPTH+2];
    logic [DEPTH:0]       found;
    logic [DEPTH-1:0]     valid_vec;

    // Result register.
    logic                 m_valid_reg;
    status_t              status_reg, status_next;
    data_t                res_reg, res_next;
    logic [CNT_BITS-1:0]  occ_reg;

    // A new beat is taken whenever the result register is free or draining.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign full  = (count_reg == CNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);

    // Command for the whole row this cycle, plus the status of the beat.
    always_comb begin
        ctl.cmd      = CMD_HOLD;
        ctl.new_data = '{sev: in_sev, pay: in_pay, tag: tag_reg};
        status_next  = ST_DONE;
        push_ok      = 1'b0;
        if (s_fire) begin
            case (in_mode)
                MODE_PRIO, MODE_FIFO: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        push_ok = 1'b1;
                        ctl.cmd = (in_mode == MODE_PRIO) ? CMD_INS_PRIO : CMD_INS_TAIL;
                    end
                end
                MODE_POP: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        ctl.cmd = CMD_POP;
                    end
                end
                default: begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    // Occupancy and arrival tag follow the command.
    always_comb begin
        count_next = count_reg;
        tag_next   = tag_reg;
        if (push_ok) begin
            count_next = count_reg + CNT_BITS'(1);
            tag_next   = tag_reg + TAG_BITS'(1);
        end else if (ctl.cmd == CMD_POP) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    // Popped fields come from the head cell; every other beat reports zeros.
    always_comb begin
        if (ctl.cmd == CMD_POP) begin
            res_next = link[1].data;
        end else begin
            res_next = '0;
        end
    end

    assign link[0]        = '0;
    assign link[DEPTH+1]  = '0;
    assign found[0]       = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .left_in   (link[i]),
            .right_in  (link[i+2]),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .entry_out (link[i+1])
        );
        assign valid_vec[i] = link[i+1].valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            tag_reg     <= TAG_BITS'(1);
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            tag_reg   <= tag_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg <= status_next;
            res_reg    <= res_next;
            occ_reg    <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, occ_reg, res_reg.tag, res_reg.pay,
                       res_reg.sev, status_reg};

    // Occupancy within depth and equal to the valid cells; tag holds without a push; pops report ST_DONE.
    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_BITS'(DEPTH), "occupancy above depth")
    `SPQ_ASSERT_NOW(a_valid_count, 1'b1, $countones(valid_vec) == 32'(count_reg), "valid cells disagree with occupancy")
    `SPQ_ASSERT_NEXT(a_tag_hold, !push_ok, $stable(tag_reg), "tag moved without a stored push")
    `SPQ_ASSERT_NEXT(a_pop_result, ctl.cmd == CMD_POP, m_valid_reg && status_reg == ST_DONE && occ_reg == $past(count_reg) - CNT_BITS'(1), "pop result wrong")

endmodule
